// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Each macro wraps one concurrent assertion clocked on clk with the synchronous reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bli_pkg.sv -----
// Package for the bracketing linear interpolator: payload structs, status codes,
// configuration register indexes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package bli_pkg;

  localparam int VALUE_W  = 32;
  localparam int MASK_W   = 4;
  localparam int CFG_AW   = 3;
  localparam int STATUS_W = 2;
  localparam int DIV_CNT_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_MATCH_VALUE       = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_LOOKUP_LOW_LIMIT  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_LOOKUP_HIGH_LIMIT = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_SHOWN_LOW_LIMIT   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_SHOWN_HIGH_LIMIT  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_LIMIT_ENABLE_MASK = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_LOWER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_UPPER = 2'd2;

  // Bits of the limit enable mask.
  localparam int EN_LOOKUP_LOW  = 0;
  localparam int EN_LOOKUP_HIGH = 1;
  localparam int EN_SHOWN_LOW   = 2;
  localparam int EN_SHOWN_HIGH  = 3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] lookup_sample;
    logic signed [VALUE_W-1:0] shown_sample;
    logic                      last_point;
  } bli_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [STATUS_W-1:0]       status;
  } bli_out_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DIV  = 4'b1000
  } bli_state_t;

endpackage

// ----- hw/rtl/bracket_linear_interpolate.sv -----
// Top level of the bracketing linear interpolator: bracket tracking, a multiply
// step and a bit-serial restoring divider under one small sequencer. Uses bli_pkg.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in_     | input     | in_valid/in_stall  | bli_in_t  (lookup, shown, last)
//  out_    | output    | out_valid/out_stall| bli_out_t (result, status)
//  cfg_    | input     | cfg_wr_en          | cfg_addr, cfg_wdata
//
// A non-last point of a set keeps the sequencer idle; the next can follow at once.
// A last point moves the sequencer to evaluate, which ends the set if no interpolation
// is needed; else a 32x32 multiply and 32 steps of the one-bit-per-cycle divider follow
// and the input waits until idle. Reset is synchronous and clears the configuration
// registers, the brackets and the output valid. A stalled result holds off every
// point; the input takes a point again once the output register is empty or draining.

module bracket_linear_interpolate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bli_pkg::bli_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bli_pkg::bli_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [bli_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [bli_pkg::VALUE_W-1:0]   cfg_wdata
);

  localparam int VW = bli_pkg::VALUE_W;

  // Configuration registers.
  logic signed [VW-1:0]             match_r, lk_low_r, lk_high_r, sh_low_r, sh_high_r;
  logic [bli_pkg::MASK_W-1:0]       en_mask_r;

  // Bracket state.
  logic                 have_lower_r, have_upper_r;
  logic signed [VW-1:0] lower_lookup_r, lower_shown_r, upper_lookup_r, upper_shown_r;

  // Sequencer and shared arithmetic.
  bli_pkg::bli_state_t             state_r, state_nxt;
  logic [VW-1:0]                   mag_r, num_r, den_r, base_r;
  logic                            neg_r;
  logic [2*VW-1:0]                 work_r;
  logic [bli_pkg::DIV_CNT_W-1:0]   cnt_r;

  logic              out_valid_r;
  bli_pkg::bli_out_t out_data_r;

  logic in_accept, skip, below, take_lower, take_upper, out_free;

  // Divider step signals.
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            qbit;
  logic [VW-1:0]   rem_nxt;
  logic [2*VW-1:0] work_step;
  logic [VW-1:0]   quot;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != bli_pkg::ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    skip = (en_mask_r[bli_pkg::EN_LOOKUP_LOW]  && (in_data.lookup_sample < lk_low_r))
        || (en_mask_r[bli_pkg::EN_LOOKUP_HIGH] && (in_data.lookup_sample > lk_high_r))
        || (en_mask_r[bli_pkg::EN_SHOWN_LOW]   && (in_data.shown_sample < sh_low_r))
        || (en_mask_r[bli_pkg::EN_SHOWN_HIGH]  && (in_data.shown_sample > sh_high_r));
    below = in_data.lookup_sample < match_r;
    // On equal lookup values the earlier point keeps the bracket.
    take_lower = !skip && below
              && (!have_lower_r || (in_data.lookup_sample > lower_lookup_r));
    take_upper = !skip && !below
              && (!have_upper_r || (in_data.lookup_sample < upper_lookup_r));
  end

  // One restoring division step: the remainder always stays below the divisor.
  always_comb begin
    trial     = {work_r[2*VW-1:VW], work_r[VW-1]};
    diff      = trial - {1'b0, den_r};
    qbit      = (trial >= {1'b0, den_r});
    rem_nxt   = qbit ? diff[VW-1:0] : trial[VW-1:0];
    work_step = {rem_nxt, work_r[VW-2:0], qbit};
    quot      = work_step[VW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bli_pkg::ST_IDLE: if (in_accept && in_data.last_point) state_nxt = bli_pkg::ST_EVAL;
      bli_pkg::ST_EVAL: begin
        if (have_lower_r && have_upper_r && (match_r < upper_lookup_r)
            && (match_r > lower_lookup_r)) begin
          state_nxt = bli_pkg::ST_MUL;
        end else begin
          state_nxt = bli_pkg::ST_IDLE;
        end
      end
      bli_pkg::ST_MUL: state_nxt = bli_pkg::ST_DIV;
      bli_pkg::ST_DIV: if (cnt_r == '1) state_nxt = bli_pkg::ST_IDLE;
      default: state_nxt = bli_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bli_pkg::ST_IDLE;
      match_r      <= '0;
      lk_low_r     <= '0;
      lk_high_r    <= '0;
      sh_low_r     <= '0;
      sh_high_r    <= '0;
      en_mask_r    <= '0;
      have_lower_r <= 1'b0;
      have_upper_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        unique case (cfg_addr)
          bli_pkg::CFG_MATCH_VALUE:       match_r   <= cfg_wdata;
          bli_pkg::CFG_LOOKUP_LOW_LIMIT:  lk_low_r  <= cfg_wdata;
          bli_pkg::CFG_LOOKUP_HIGH_LIMIT: lk_high_r <= cfg_wdata;
          bli_pkg::CFG_SHOWN_LOW_LIMIT:   sh_low_r  <= cfg_wdata;
          bli_pkg::CFG_SHOWN_HIGH_LIMIT:  sh_high_r <= cfg_wdata;
          bli_pkg::CFG_LIMIT_ENABLE_MASK: en_mask_r <= cfg_wdata[bli_pkg::MASK_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        bli_pkg::ST_IDLE: begin
          if (in_accept && take_lower) have_lower_r <= 1'b1;
          if (in_accept && take_upper) have_upper_r <= 1'b1;
          cnt_r <= '0;
        end
        bli_pkg::ST_EVAL: begin
          // Every set ends with the brackets cleared.
          have_lower_r <= 1'b0;
          have_upper_r <= 1'b0;
          if (state_nxt == bli_pkg::ST_IDLE) out_valid_r <= 1'b1;
        end
        bli_pkg::ST_MUL: ;
        bli_pkg::ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    unique case (state_r)
      bli_pkg::ST_IDLE: begin
        if (in_accept && take_lower) begin
          lower_lookup_r <= in_data.lookup_sample;
          lower_shown_r  <= in_data.shown_sample;
        end
        if (in_accept && take_upper) begin
          upper_lookup_r <= in_data.lookup_sample;
          upper_shown_r  <= in_data.shown_sample;
        end
      end
      bli_pkg::ST_EVAL: begin
        base_r <= upper_shown_r;
        num_r  <= upper_lookup_r - match_r;
        den_r  <= upper_lookup_r - lower_lookup_r;
        neg_r  <= upper_shown_r < lower_shown_r;
        mag_r  <= (upper_shown_r < lower_shown_r) ? (lower_shown_r - upper_shown_r)
                                                  : (upper_shown_r - lower_shown_r);
        if (!have_lower_r) begin
          out_data_r.result_value <= '0;
          out_data_r.status       <= bli_pkg::STATUS_NO_LOWER;
        end else if (!have_upper_r) begin
          out_data_r.result_value <= '0;
          out_data_r.status       <= bli_pkg::STATUS_NO_UPPER;
        end else if (match_r >= upper_lookup_r) begin
          out_data_r.result_value <= upper_shown_r;
          out_data_r.status       <= bli_pkg::STATUS_OK;
        end else if (match_r <= lower_lookup_r) begin
          out_data_r.result_value <= lower_shown_r;
          out_data_r.status       <= bli_pkg::STATUS_OK;
        end
      end
      bli_pkg::ST_MUL: begin
        // The high half of this product is below the divisor since num < den.
        work_r <= mag_r * num_r;
      end
      bli_pkg::ST_DIV: begin
        work_r <= work_step;
        if (cnt_r == '1) begin
          out_data_r.result_value <= neg_r ? (base_r + quot) : (base_r - quot);
          out_data_r.status       <= bli_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/bli_checker.sv -----
// Port-level checker for the bracketing linear interpolator, bound to the top level.
// Depends on bli_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bli_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input bli_pkg::bli_in_t              in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input bli_pkg::bli_out_t             out_data
);

  // A waiting result stays offered until it is taken.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "stalled result changed")

  // Only a last point produces a result, so a point that is not last adds none.
  `ASSERT_NEXT(a_no_spurious, clk, rst_n, in_valid && !in_stall && !in_data.last_point && !out_valid, !out_valid, "result without a last point")

  // A missing bracket always comes with a zero value.
  `ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && (out_data.status != bli_pkg::STATUS_OK), out_data.result_value == '0, "error result is not zero")

endmodule

bind bracket_linear_interpolate bli_checker u_bli_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for bracket_linear_interpolate: a directed table of data points
// and register writes, then random data sets under idle, stall and hold-off phases.
// Depends on bli_pkg and the bracket_linear_interpolate RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 4000;
  localparam int N_PHASES       = 9;
  localparam int PRESSURE_PHASE = 8;

  localparam logic [bli_pkg::VALUE_W-1:0] EXT_MAX = 32'h7FFF_FFFF;
  localparam logic [bli_pkg::VALUE_W-1:0] EXT_MIN = 32'h8000_0000;
  localparam logic [bli_pkg::VALUE_W-1:0] NEAR    = 32'h0003_0000;
  localparam logic [bli_pkg::VALUE_W-1:0] SMALL   = 32'h0004_0000;

  typedef struct {
    bit                           is_write;
    logic [bli_pkg::CFG_AW-1:0]   addr;
    logic [bli_pkg::VALUE_W-1:0]  wdata;
    bli_pkg::bli_in_t             pt;
    bit                           typed;
    bli_pkg::bli_out_t            exp;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  bli_pkg::bli_in_t             in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  bli_pkg::bli_out_t            out_data;
  logic                         cfg_wr_en = 1'b0;
  logic [bli_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [bli_pkg::VALUE_W-1:0]  cfg_wdata = '0;

  // A hand-typed expectation travels with the point that carries it.
  bit                           note_typed = 1'b0;
  bli_pkg::bli_out_t            note_exp = '0;

  // Register copy and bracket state of the predictor.
  logic signed [bli_pkg::VALUE_W-1:0] reg_match = '0, reg_lk_lo = '0, reg_lk_hi = '0;
  logic signed [bli_pkg::VALUE_W-1:0] reg_sh_lo = '0, reg_sh_hi = '0;
  logic [bli_pkg::MASK_W-1:0]         reg_mask = '0;
  bit                                 br_have_lo = 1'b0, br_have_hi = 1'b0;
  logic signed [bli_pkg::VALUE_W-1:0] br_lo_lk = '0, br_lo_sh = '0;
  logic signed [bli_pkg::VALUE_W-1:0] br_hi_lk = '0, br_hi_sh = '0;

  bli_pkg::bli_out_t result_q[$];
  stim_row_t         stim_table[$];

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  quiet = 0;
  int  fail_count = 0;
  int  n_points = 0;
  int  n_results = 0;
  int  n_writes = 0;

  bracket_linear_interpolate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Updates the brackets with one point and, on the last point of a set, forms its result.
  function automatic bit track_point(input bli_pkg::bli_in_t p, output bli_pkg::bli_out_t r);
    logic signed [bli_pkg::VALUE_W-1:0] lk, sh;
    logic [bli_pkg::VALUE_W-1:0]        gap, span, mag;
    logic [2*bli_pkg::VALUE_W-1:0]      q;
    bit                                 drop;
    lk = p.lookup_sample;
    sh = p.shown_sample;
    r = '0;
    drop = (reg_mask[bli_pkg::EN_LOOKUP_LOW] && lk < reg_lk_lo) ||
           (reg_mask[bli_pkg::EN_LOOKUP_HIGH] && lk > reg_lk_hi) ||
           (reg_mask[bli_pkg::EN_SHOWN_LOW] && sh < reg_sh_lo) ||
           (reg_mask[bli_pkg::EN_SHOWN_HIGH] && sh > reg_sh_hi);
    if (!drop) begin
      if (lk < reg_match) begin
        if (!br_have_lo || lk > br_lo_lk) begin
          br_have_lo = 1'b1;
          br_lo_lk = lk;
          br_lo_sh = sh;
        end
      end else if (!br_have_hi || lk < br_hi_lk) begin
        br_have_hi = 1'b1;
        br_hi_lk = lk;
        br_hi_sh = sh;
      end
    end
    if (!p.last_point) return 1'b0;
    if (!br_have_lo) begin
      r.status = bli_pkg::STATUS_NO_LOWER;
    end else if (!br_have_hi) begin
      r.status = bli_pkg::STATUS_NO_UPPER;
    end else if (reg_match >= br_hi_lk) begin
      r.result_value = br_hi_sh;
    end else if (reg_match <= br_lo_lk) begin
      r.result_value = br_lo_sh;
    end else begin
      // The product of two 32-bit magnitudes fits in 64 bits, so nothing is lost before the division.
      gap  = br_hi_lk - reg_match;
      span = br_hi_lk - br_lo_lk;
      if (br_hi_sh >= br_lo_sh) mag = br_hi_sh - br_lo_sh;
      else mag = br_lo_sh - br_hi_sh;
      q = ({{bli_pkg::VALUE_W{1'b0}}, mag} * {{bli_pkg::VALUE_W{1'b0}}, gap})
          / {{bli_pkg::VALUE_W{1'b0}}, span};
      if (br_hi_sh >= br_lo_sh) r.result_value = br_hi_sh - q[bli_pkg::VALUE_W-1:0];
      else r.result_value = br_hi_sh + q[bli_pkg::VALUE_W-1:0];
    end
    br_have_lo = 1'b0;
    br_have_hi = 1'b0;
    br_lo_lk = '0;
    br_lo_sh = '0;
    br_hi_lk = '0;
    br_hi_sh = '0;
    return 1'b1;
  endfunction

  function automatic void row_point(input logic [bli_pkg::VALUE_W-1:0] lk,
                                    input logic [bli_pkg::VALUE_W-1:0] sh,
                                    input bit last);
    stim_row_t row;
    row = '{default: '0};
    row.pt.lookup_sample = lk;
    row.pt.shown_sample = sh;
    row.pt.last_point = last;
    stim_table.push_back(row);
  endfunction

  function automatic void row_result(input logic [bli_pkg::VALUE_W-1:0] lk,
                                     input logic [bli_pkg::VALUE_W-1:0] sh,
                                     input logic [bli_pkg::VALUE_W-1:0] val,
                                     input logic [bli_pkg::STATUS_W-1:0] st);
    stim_row_t row;
    row = '{default: '0};
    row.pt.lookup_sample = lk;
    row.pt.shown_sample = sh;
    row.pt.last_point = 1'b1;
    row.typed = 1'b1;
    row.exp.result_value = val;
    row.exp.status = st;
    stim_table.push_back(row);
  endfunction

  function automatic void row_write(input logic [bli_pkg::CFG_AW-1:0] addr,
                                    input logic [bli_pkg::VALUE_W-1:0] data);
    stim_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.addr = addr;
    row.wdata = data;
    stim_table.push_back(row);
  endfunction

  function automatic logic [bli_pkg::VALUE_W-1:0] pick_lookup();
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2:       return reg_match;
      3:       return $urandom_range(1) ? EXT_MAX : EXT_MIN;
      default: return reg_match + $urandom_range(2 * NEAR) - NEAR;
    endcase
  endfunction

  function automatic logic [bli_pkg::VALUE_W-1:0] pick_shown();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4:          return $urandom_range(1) ? EXT_MAX : EXT_MIN;
      default:    return $urandom_range(2 * SMALL) - SMALL;
    endcase
  endfunction

  // Offers one point and returns at the edge where the transaction completes.
  task automatic send_point(input bli_pkg::bli_in_t p, input bit typed,
                            input bli_pkg::bli_out_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    note_typed <= typed;
    note_exp <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending, waits until every expected result has been taken, then waits out the drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bli_pkg::CFG_AW-1:0] addr,
                           input logic [bli_pkg::VALUE_W-1:0] data);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      bli_pkg::CFG_MATCH_VALUE:       reg_match = data;
      bli_pkg::CFG_LOOKUP_LOW_LIMIT:  reg_lk_lo = data;
      bli_pkg::CFG_LOOKUP_HIGH_LIMIT: reg_lk_hi = data;
      bli_pkg::CFG_SHOWN_LOW_LIMIT:   reg_sh_lo = data;
      bli_pkg::CFG_SHOWN_HIGH_LIMIT:  reg_sh_hi = data;
      bli_pkg::CFG_LIMIT_ENABLE_MASK: reg_mask = data[bli_pkg::MASK_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int ph);
    logic [bli_pkg::VALUE_W-1:0] m, llo, lhi, slo, shi;
    logic [bli_pkg::MASK_W-1:0]  en;
    m   = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(2 * SMALL) - SMALL;
    llo = m - $urandom_range(32'h0005_0000);
    lhi = m + $urandom_range(32'h0005_0000);
    slo = -$urandom_range(32'h4000_0000);
    shi = $urandom_range(32'h4000_0000);
    en  = bli_pkg::MASK_W'($urandom_range(15));
    case (ph)
      0: en = '0;
      1: begin
        m = EXT_MIN;
        llo = EXT_MIN;
        lhi = EXT_MAX;
        slo = EXT_MIN;
        shi = EXT_MAX;
        en = '1;
      end
      2: begin
        m = EXT_MAX;
        en = '0;
      end
      PRESSURE_PHASE: en = '0;
      default: ;
    endcase
    write_reg(bli_pkg::CFG_MATCH_VALUE, m);
    write_reg(bli_pkg::CFG_LOOKUP_LOW_LIMIT, llo);
    write_reg(bli_pkg::CFG_LOOKUP_HIGH_LIMIT, lhi);
    write_reg(bli_pkg::CFG_SHOWN_LOW_LIMIT, slo);
    write_reg(bli_pkg::CFG_SHOWN_HIGH_LIMIT, shi);
    write_reg(bli_pkg::CFG_LIMIT_ENABLE_MASK, bli_pkg::VALUE_W'(en));
  endtask

  task automatic send_set(input int len);
    bli_pkg::bli_in_t  p;
    bli_pkg::bli_out_t none;
    none = '0;
    for (int k = 0; k < len; k++) begin
      p.lookup_sample = pick_lookup();
      p.shown_sample = pick_shown();
      p.last_point = (k == len - 1);
      send_point(p, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin : check_proc
    bli_pkg::bli_out_t pred, want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_points++;
        if (track_point(in_data, pred)) result_q.push_back(note_typed ? note_exp : pred);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (result_q.size() == 0) begin
          $error("result with none expected: result_value=%0d status=%0d",
                 out_data.result_value, out_data.status);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_data.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   out_data.result_value);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
        end
      end
    end
  end

  // The receiver owns its hold-off count; a toggle of hold_req starts one long stall.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int sent, len, goal;
    bit paused;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: match at zero, no limits enabled.
    row_result(EXT_MIN, EXT_MAX, '0, bli_pkg::STATUS_NO_UPPER);
    row_result(32'h0, 32'h5, '0, bli_pkg::STATUS_NO_LOWER);
    row_point(32'hFFFF_0000, 32'd100, 1'b0);
    row_result(32'h0, 32'h1234_5678, 32'h1234_5678, bli_pkg::STATUS_OK);
    row_point(32'hFFFE_0000, 32'h0, 1'b0);
    row_result(32'h0002_0000, 32'h0004_0000, 32'h0002_0000, bli_pkg::STATUS_OK);
    row_point(EXT_MIN, EXT_MIN, 1'b0);
    row_point(EXT_MAX, EXT_MAX, 1'b1);
    row_point(EXT_MIN, EXT_MAX, 1'b0);
    row_point(EXT_MAX, EXT_MIN, 1'b1);
    // Equal lookups: the first kept point stays the bracket.
    row_point(32'hFFFF_FFFB, 32'd11, 1'b0);
    row_point(32'hFFFF_FFFB, 32'd22, 1'b0);
    row_point(32'd7, 32'd33, 1'b0);
    row_point(32'd7, 32'd44, 1'b1);
    // Every limit enabled; each point trips a different one, so the set is empty.
    row_write(bli_pkg::CFG_LOOKUP_LOW_LIMIT, 32'hFFFF_0000);
    row_write(bli_pkg::CFG_LOOKUP_HIGH_LIMIT, 32'h0001_0000);
    row_write(bli_pkg::CFG_SHOWN_LOW_LIMIT, 32'hFFFF_FF9C);
    row_write(bli_pkg::CFG_SHOWN_HIGH_LIMIT, 32'd100);
    row_write(bli_pkg::CFG_LIMIT_ENABLE_MASK, 32'hF);
    row_point(32'hFFFE_0000, 32'h0, 1'b0);
    row_point(32'h0002_0000, 32'h0, 1'b0);
    row_point(32'hFFFF_FFFF, 32'hFFFF_FF38, 1'b0);
    row_result(32'h1, 32'd200, '0, bli_pkg::STATUS_NO_LOWER);
    // Match moved mid-set onto the upper bracket, then onto the lower one.
    row_point(32'hFFFF_8000, 32'd10, 1'b0);
    row_point(32'h0000_8000, 32'd50, 1'b0);
    row_write(bli_pkg::CFG_MATCH_VALUE, 32'h0000_8000);
    row_result(32'h0002_0000, 32'h0, 32'd50, bli_pkg::STATUS_OK);
    row_point(32'hFFFF_8000, 32'd10, 1'b0);
    row_point(32'h0000_C000, 32'd60, 1'b0);
    row_write(bli_pkg::CFG_MATCH_VALUE, 32'hFFFF_8000);
    row_result(32'hFFFE_0000, 32'h0, 32'd10, bli_pkg::STATUS_OK);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_write) write_reg(stim_table[i].addr, stim_table[i].wdata);
      else send_point(stim_table[i].pt, stim_table[i].typed, stim_table[i].exp);
    end

    paused = 1'b0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      configure(ph);
      case ((ph == PRESSURE_PHASE) ? 0 : ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 79;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 79;
        end
        default: begin
          send_idle_pct = 11;
          stall_pct = 11;
        end
      endcase
      if (ph == PRESSURE_PHASE) hold_req <= ~hold_req;
      goal = (ph == 1 || ph == 2) ? 80 : (ph == PRESSURE_PHASE) ? 150 : 250;
      sent = 0;
      while (sent < goal) begin
        if (ph == PRESSURE_PHASE) len = $urandom_range(1, 2);
        else if ($urandom_range(3) == 0) len = $urandom_range(1, 12);
        else len = $urandom_range(1, 4);
        send_set(len);
        sent += len;
        // Let the block empty completely before the sender resumes.
        if (ph == 4 && !paused && sent >= goal / 2) begin
          paused = 1'b1;
          in_valid <= 1'b0;
          @(posedge clk);
          while (result_q.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d points, %0d results and %0d register writes", n_points, n_results,
             n_writes);
    $display("across idle, stall, hold-off and limit-extreme phases.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bli_pkg.sv
hw/rtl/bracket_linear_interpolate.sv
hw/rtl/bli_checker.sv
dv/testbench.sv
